>>> design/token_bucket_channel_prioritizer_defines.svh
// Assertion helpers for the channel prioritizer.
`ifndef TOKEN_BUCKET_CHANNEL_PRIORITIZER_DEFINES_SVH
`define TOKEN_BUCKET_CHANNEL_PRIORITIZER_DEFINES_SVH

`ifndef SYNTHESIS

`define TBCP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tbcp same-cycle check failed");

`define TBCP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tbcp next-cycle check failed");

`else

`define TBCP_ASSERT_IMP(label, clk, rst, ante, cons)

`define TBCP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> design/tbcp_pkg.sv
package tbcp_pkg;

  localparam int NUM_CHANNELS = 16;
  localparam int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  localparam int CHAN_W      = 4;
  localparam int AMOUNT_W    = 32;
  localparam int SLOT_W      = 32;
  localparam int RATE_W      = 24;
  localparam int DEPTH_W     = 16;
  localparam int BKT_W       = 48;
  localparam int CAP_W       = RATE_W + DEPTH_W;
  localparam int PROD_W      = SLOT_W + RATE_W;
  localparam int ALU_W       = PROD_W + 2;
  localparam int TOTAL_OUT_W = 36;
  // exact running sum of all buffers
  localparam int TOTAL_W     = AMOUNT_W + $clog2(NUM_CHANNELS);

  localparam logic [TOTAL_OUT_W-1:0] TOTAL_MAX = '1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_CHANNEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_CHANNEL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_SLOT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_DEPTH  = 2'd3;

  localparam logic [CHAN_W-1:0]  FIRST_CHANNEL_RST = 4'd0;
  localparam logic [CHAN_W-1:0]  LAST_CHANNEL_RST  = 4'd15;
  localparam logic [RATE_W-1:0]  BITS_PER_SLOT_RST = 24'd1024000;
  localparam logic [DEPTH_W-1:0] BUCKET_DEPTH_RST  = 16'd1000;

  typedef enum logic [1:0] {
    OP_ARRIVAL = 2'd0,
    OP_GRANT   = 2'd1,
    OP_REFRESH = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef struct packed {
    logic [ALU_W-1:0]    add_a;
    logic [ALU_W-1:0]    add_b;
    logic                sub;
    logic [SLOT_W-1:0]   mul_a;
    logic [RATE_W-1:0]   mul_b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0]  sum;
    logic [PROD_W-1:0] prod;
  } alu_res_t;

  typedef struct packed {
    logic                buf_we;
    logic [IDX_W-1:0]    buf_idx;
    logic [AMOUNT_W-1:0] buf_data;
    logic                bkt_we;
    logic [IDX_W-1:0]    bkt_idx;
    logic [BKT_W-1:0]    bkt_data;
    logic                slot_we;
    logic [IDX_W-1:0]    slot_idx;
    logic [SLOT_W-1:0]   slot_data;
  } store_wr_t;

endpackage

>>> design/tbcp_alu.sv
module tbcp_alu (
  input  tbcp_pkg::alu_req_t req,
  output tbcp_pkg::alu_res_t res
);
  import tbcp_pkg::*;

  logic [ALU_W-1:0] add_b_eff;

  assign add_b_eff = req.sub ? ~req.add_b : req.add_b;

  always_comb begin
    res.sum  = req.add_a + add_b_eff + ALU_W'(req.sub);
    res.prod = PROD_W'(req.mul_a) * PROD_W'(req.mul_b);
  end

endmodule

>>> design/tbcp_chan_store.sv
module tbcp_chan_store (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [tbcp_pkg::IDX_W-1:0]      rd_idx,
  input  tbcp_pkg::store_wr_t             wr,
  output logic [tbcp_pkg::AMOUNT_W-1:0]   rd_buf,
  output logic [tbcp_pkg::BKT_W-1:0]      rd_bkt,
  output logic [tbcp_pkg::SLOT_W-1:0]     rd_slot
);
  import tbcp_pkg::*;

  logic [AMOUNT_W-1:0] buf_mem  [NUM_CHANNELS];
  logic [BKT_W-1:0]    bkt_mem  [NUM_CHANNELS];
  logic [SLOT_W-1:0]   slot_mem [NUM_CHANNELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        buf_mem[k]  <= '0;
        bkt_mem[k]  <= '0;
        slot_mem[k] <= '0;
      end
    end else begin
      if (wr.buf_we) begin
        buf_mem[wr.buf_idx] <= wr.buf_data;
      end
      if (wr.bkt_we) begin
        bkt_mem[wr.bkt_idx] <= wr.bkt_data;
      end
      if (wr.slot_we) begin
        slot_mem[wr.slot_idx] <= wr.slot_data;
      end
    end
  end

  assign rd_buf  = buf_mem[rd_idx];
  assign rd_bkt  = bkt_mem[rd_idx];
  assign rd_slot = slot_mem[rd_idx];

endmodule

>>> design/token_bucket_channel_prioritizer.sv
// Token bucket channel prioritizer.
// Command channel: present opcode, channel, amount_bits and current_slot with
// start; the beat is taken on a clock edge where start is high and busy low.
// busy stays high until the result beat, which shows for one cycle with done
// high on channel_buffer, remaining_grant, total_buffered and any_data.
// The receiver cannot stall; the result is simply dropped if not captured.
// An arrival runs sum, write and total states; a refresh runs elapsed,
// product, cap and clamp states; a grant walks channels, then flushes;
// no-op and a grant with first_channel above last_channel skip to the result.
// A new command may be taken in the cycle done is high.
// The grant walk serves one channel per cycle; bucket refresh goes through
// one shared 32x24 multiplier and one 58 bit adder, one step per cycle.
// Config port: cfg_we writes cfg_wdata into register cfg_idx (0 first_channel,
// 1 last_channel, 2 bits_per_slot, 3 bucket_depth_slots); write only while idle.
// Synchronous reset clears all buffers, buckets, service slots and the total,
// and loads the default configuration.
`include "token_bucket_channel_prioritizer_defines.svh"

module token_bucket_channel_prioritizer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          opcode,
  input  logic [tbcp_pkg::CHAN_W-1:0]         channel,
  input  logic [tbcp_pkg::AMOUNT_W-1:0]       amount_bits,
  input  logic [tbcp_pkg::SLOT_W-1:0]         current_slot,
  input  logic                                cfg_we,
  input  logic [tbcp_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [tbcp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic                                done,
  output logic [tbcp_pkg::AMOUNT_W-1:0]       channel_buffer,
  output logic [tbcp_pkg::AMOUNT_W-1:0]       remaining_grant,
  output logic [tbcp_pkg::TOTAL_OUT_W-1:0]    total_buffered,
  output logic                                any_data
);
  import tbcp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ARR_SUM,
    ST_ARR_WRITE,
    ST_ARR_TOTAL,
    ST_REF_ELAPSED,
    ST_REF_PROD,
    ST_REF_CAP,
    ST_REF_CLAMP,
    ST_WALK,
    ST_FLUSH,
    ST_FIN
  } state_t;

  state_t              state;

  logic [CHAN_W-1:0]   first_ch;
  logic [CHAN_W-1:0]   last_ch;
  logic [RATE_W-1:0]   bps;
  logic [DEPTH_W-1:0]  depth;

  logic [CHAN_W-1:0]   ch_q;
  logic [AMOUNT_W-1:0] amount_q;
  logic [SLOT_W-1:0]   now_q;
  logic [CHAN_W-1:0]   i_q;
  logic [AMOUNT_W-1:0] left_q;
  logic [AMOUNT_W-1:0] chan_q;
  logic [ALU_W-1:0]    acc_q;
  logic [PROD_W-1:0]   prod_q;
  logic [CAP_W-1:0]    cap_q;
  logic [AMOUNT_W-1:0] served_q;
  logic [BKT_W-1:0]    bkt_q;
  logic                pend_q;
  logic [CHAN_W-1:0]   pend_idx_q;
  logic [TOTAL_W-1:0]  total_q;

  alu_req_t            alu_req;
  alu_res_t            alu_res;
  store_wr_t           st_wr;
  logic [IDX_W-1:0]    rd_idx;
  logic [AMOUNT_W-1:0] rd_buf;
  logic [BKT_W-1:0]    rd_bkt;
  logic [SLOT_W-1:0]   rd_slot;

  logic                in_valid_ch;
  logic                walk_valid;
  logic                bkt_pos;
  logic                eligible;
  logic [AMOUNT_W:0]   diff;
  logic                fits;
  logic [AMOUNT_W-1:0] buf_new;
  logic [AMOUNT_W-1:0] left_new;
  logic [AMOUNT_W-1:0] served;
  logic [AMOUNT_W-1:0] arr_buf;
  logic [BKT_W-1:0]    clamp_lvl;
  logic [TOTAL_W-1:0]  total_sub;
  logic [TOTAL_OUT_W-1:0] total_sat;

  tbcp_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  tbcp_chan_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_idx  (rd_idx),
    .wr      (st_wr),
    .rd_buf  (rd_buf),
    .rd_bkt  (rd_bkt),
    .rd_slot (rd_slot)
  );

  assign busy = (state != ST_IDLE);

  assign in_valid_ch = (32'(channel) < 32'(NUM_CHANNELS));
  assign rd_idx      = (state == ST_WALK) ? IDX_W'(i_q) : IDX_W'(ch_q);

  // walk step: one subtract decides both the fit and the new buffer
  assign walk_valid = (32'(i_q) < 32'(NUM_CHANNELS));
  assign bkt_pos    = !rd_bkt[BKT_W-1] && (rd_bkt != '0);
  assign eligible   = walk_valid && bkt_pos && (rd_buf != '0);
  assign diff       = {1'b0, rd_buf} - {1'b0, left_q};
  assign fits       = !diff[AMOUNT_W];
  assign buf_new    = fits ? diff[AMOUNT_W-1:0] : '0;
  assign left_new   = fits ? '0 : (left_q - rd_buf);
  assign served     = fits ? left_q : rd_buf;

  assign arr_buf    = acc_q[AMOUNT_W] ? '1 : acc_q[AMOUNT_W-1:0];
  // sign bit set means cap < level sum
  assign clamp_lvl  = alu_res.sum[ALU_W-1] ? BKT_W'(cap_q) : acc_q[BKT_W-1:0];
  assign total_sub  = total_q - TOTAL_W'(served_q);
  assign total_sat  = (total_q > TOTAL_W'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_OUT_W'(total_q);

  always_comb begin
    alu_req = '0;
    case (state)
      ST_ARR_SUM: begin
        alu_req.add_a = ALU_W'(rd_buf);
        alu_req.add_b = ALU_W'(amount_q);
      end
      ST_ARR_WRITE: begin
        alu_req.add_a = ALU_W'(arr_buf);
        alu_req.add_b = ALU_W'(rd_buf);
        alu_req.sub   = 1'b1;
      end
      ST_REF_ELAPSED: begin
        alu_req.add_a = ALU_W'(now_q);
        alu_req.add_b = ALU_W'(rd_slot);
        alu_req.sub   = 1'b1;
      end
      ST_REF_PROD: begin
        alu_req.mul_a = acc_q[SLOT_W-1:0];
        alu_req.mul_b = bps;
      end
      ST_REF_CAP: begin
        alu_req.mul_a = SLOT_W'(depth);
        alu_req.mul_b = bps;
        alu_req.add_a = {{(ALU_W-BKT_W){rd_bkt[BKT_W-1]}}, rd_bkt};
        alu_req.add_b = ALU_W'(prod_q);
      end
      ST_REF_CLAMP: begin
        alu_req.add_a = ALU_W'(cap_q);
        alu_req.add_b = acc_q;
        alu_req.sub   = 1'b1;
      end
      ST_WALK, ST_FLUSH: begin
        // bucket debit of the channel served in the previous walk step
        alu_req.add_a = {{(ALU_W-BKT_W){bkt_q[BKT_W-1]}}, bkt_q};
        alu_req.add_b = ALU_W'(served_q);
        alu_req.sub   = 1'b1;
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  always_comb begin
    st_wr = '0;
    case (state)
      ST_ARR_WRITE: begin
        st_wr.buf_we   = 1'b1;
        st_wr.buf_idx  = IDX_W'(ch_q);
        st_wr.buf_data = arr_buf;
      end
      ST_REF_CLAMP: begin
        st_wr.bkt_we   = 1'b1;
        st_wr.bkt_idx  = IDX_W'(ch_q);
        st_wr.bkt_data = clamp_lvl;
      end
      ST_WALK: begin
        st_wr.buf_we    = eligible;
        st_wr.buf_idx   = IDX_W'(i_q);
        st_wr.buf_data  = buf_new;
        st_wr.slot_we   = eligible;
        st_wr.slot_idx  = IDX_W'(i_q);
        st_wr.slot_data = now_q;
        st_wr.bkt_we    = pend_q;
        st_wr.bkt_idx   = IDX_W'(pend_idx_q);
        st_wr.bkt_data  = alu_res.sum[BKT_W-1:0];
      end
      ST_FLUSH: begin
        st_wr.bkt_we   = pend_q;
        st_wr.bkt_idx  = IDX_W'(pend_idx_q);
        st_wr.bkt_data = alu_res.sum[BKT_W-1:0];
      end
      default: begin
        st_wr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      done     <= 1'b0;
      pend_q   <= 1'b0;
      total_q  <= '0;
      first_ch <= FIRST_CHANNEL_RST;
      last_ch  <= LAST_CHANNEL_RST;
      bps      <= BITS_PER_SLOT_RST;
      depth    <= BUCKET_DEPTH_RST;
    end else begin
      done <= (state == ST_FIN);

      if (cfg_we) begin
        case (cfg_idx)
          REG_FIRST_CHANNEL: first_ch <= cfg_wdata[CHAN_W-1:0];
          REG_LAST_CHANNEL:  last_ch  <= cfg_wdata[CHAN_W-1:0];
          REG_BITS_PER_SLOT: bps      <= cfg_wdata[RATE_W-1:0];
          REG_BUCKET_DEPTH:  depth    <= cfg_wdata[DEPTH_W-1:0];
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (start) begin
            ch_q     <= channel;
            amount_q <= amount_bits;
            now_q    <= current_slot;
            chan_q   <= '0;
            i_q      <= first_ch;
            pend_q   <= 1'b0;
            left_q   <= (op_t'(opcode) == OP_GRANT) ? amount_bits : '0;
            case (op_t'(opcode))
              OP_ARRIVAL: begin
                state <= in_valid_ch ? ST_ARR_SUM : ST_FIN;
              end
              OP_REFRESH: begin
                state <= in_valid_ch ? ST_REF_ELAPSED : ST_FIN;
              end
              OP_GRANT: begin
                state <= (first_ch > last_ch) ? ST_FIN : ST_WALK;
              end
              default: begin
                state <= ST_FIN;
              end
            endcase
          end
        end
        ST_ARR_SUM: begin
          acc_q <= alu_res.sum;
          state <= ST_ARR_WRITE;
        end
        ST_ARR_WRITE: begin
          acc_q  <= alu_res.sum;  // growth of the buffer
          chan_q <= arr_buf;
          state  <= ST_ARR_TOTAL;
        end
        ST_ARR_TOTAL: begin
          total_q <= total_q + TOTAL_W'(acc_q[AMOUNT_W-1:0]);
          state   <= ST_FIN;
        end
        ST_REF_ELAPSED: begin
          acc_q <= alu_res.sum;
          state <= ST_REF_PROD;
        end
        ST_REF_PROD: begin
          prod_q <= alu_res.prod;
          state  <= ST_REF_CAP;
        end
        ST_REF_CAP: begin
          cap_q <= alu_res.prod[CAP_W-1:0];
          acc_q <= alu_res.sum;
          state <= ST_REF_CLAMP;
        end
        ST_REF_CLAMP: begin
          chan_q <= rd_buf;
          state  <= ST_FIN;
        end
        ST_WALK: begin
          if (pend_q) begin
            total_q <= total_sub;
          end
          pend_q     <= eligible;
          pend_idx_q <= i_q;
          served_q   <= served;
          bkt_q      <= rd_bkt;
          if (eligible) begin
            left_q <= left_new;
          end
          if ((eligible && fits) || (i_q == last_ch)) begin
            state <= ST_FLUSH;
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
        ST_FLUSH: begin
          if (pend_q) begin
            total_q <= total_sub;
          end
          pend_q <= 1'b0;
          state  <= ST_FIN;
        end
        ST_FIN: begin
          channel_buffer  <= chan_q;
          remaining_grant <= left_q;
          total_buffered  <= total_sat;
          any_data        <= (total_q != '0);
          state           <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `TBCP_ASSERT_IMP(a_done_not_busy, clk, rst, done, !busy)
  `TBCP_ASSERT_NEXT(a_accept_goes_busy, clk, rst, start && !busy, busy)
  `TBCP_ASSERT_NEXT(a_done_one_cycle, clk, rst, done, !done)
  `TBCP_ASSERT_IMP(a_any_data_total, clk, rst, done, any_data == (total_buffered != '0))

endmodule

>>> dv/tb_top.sv
module tb_top;
  import tbcp_pkg::*;

  typedef struct packed {
    logic [AMOUNT_W-1:0]    chan_buf;
    logic [AMOUNT_W-1:0]    left_over;
    logic [TOTAL_OUT_W-1:0] total;
    logic                   any_flag;
  } report_t;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic [1:0]             opcode;
  logic [CHAN_W-1:0]      channel;
  logic [AMOUNT_W-1:0]    amount_bits;
  logic [SLOT_W-1:0]      current_slot;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_idx;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   done;
  logic [AMOUNT_W-1:0]    channel_buffer;
  logic [AMOUNT_W-1:0]    remaining_grant;
  logic [TOTAL_OUT_W-1:0] total_buffered;
  logic                   any_data;

  // shadow of the block state
  logic [AMOUNT_W-1:0] chan_bits [NUM_CHANNELS];
  longint              bucket_lvl [NUM_CHANNELS];
  logic [SLOT_W-1:0]   served_slot [NUM_CHANNELS];
  logic [CHAN_W-1:0]   cfg_first;
  logic [CHAN_W-1:0]   cfg_last;
  logic [RATE_W-1:0]   cfg_rate;
  logic [DEPTH_W-1:0]  cfg_depth;

  report_t             predicted_reports [$];
  int                  mismatch_count;
  logic [SLOT_W-1:0]   slot_clock;

  token_bucket_channel_prioritizer dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .opcode         (opcode),
    .channel        (channel),
    .amount_bits    (amount_bits),
    .current_slot   (current_slot),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .done           (done),
    .channel_buffer (channel_buffer),
    .remaining_grant(remaining_grant),
    .total_buffered (total_buffered),
    .any_data       (any_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #(12 * 400000);
    $display("token_bucket_channel_prioritizer test failed");
    $finish;
  end

  function automatic void clear_shadow();
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      chan_bits[i]   = '0;
      bucket_lvl[i]  = 0;
      served_slot[i] = '0;
    end
    cfg_first = FIRST_CHANNEL_RST;
    cfg_last  = LAST_CHANNEL_RST;
    cfg_rate  = BITS_PER_SLOT_RST;
    cfg_depth = BUCKET_DEPTH_RST;
  endfunction

  function automatic report_t predict_report(op_t op, logic [CHAN_W-1:0] ch,
                                             logic [AMOUNT_W-1:0] amt,
                                             logic [SLOT_W-1:0] now);
    report_t             r;
    logic [AMOUNT_W:0]   s;
    logic [AMOUNT_W-1:0] left;
    logic [AMOUNT_W-1:0] served;
    logic [SLOT_W-1:0]   elapsed;
    longint              lvl;
    longint              cap;
    longint              sum;
    bit                  stop;
    int                  i;
    r = '0;
    case (op)
      OP_ARRIVAL: begin
        s = {1'b0, chan_bits[ch]} + {1'b0, amt};
        chan_bits[ch] = s[AMOUNT_W] ? '1 : s[AMOUNT_W-1:0];
        r.chan_buf = chan_bits[ch];
      end
      OP_GRANT: begin
        left = amt;
        stop = 1'b0;
        if (cfg_first <= cfg_last) begin
          for (i = cfg_first; i <= cfg_last && !stop; i++) begin
            if (bucket_lvl[i] > 0 && chan_bits[i] != 0) begin
              stop = (chan_bits[i] >= left);
              served = stop ? left : chan_bits[i];
              left = left - served;
              served_slot[i] = now;
              bucket_lvl[i] = bucket_lvl[i] - longint'(served);
              chan_bits[i] = chan_bits[i] - served;
            end
          end
        end
        r.left_over = left;
      end
      OP_REFRESH: begin
        elapsed = now - served_slot[ch];
        cap = longint'(cfg_rate) * longint'(cfg_depth);
        lvl = bucket_lvl[ch] + longint'(elapsed) * longint'(cfg_rate);
        if (lvl > cap) lvl = cap;
        bucket_lvl[ch] = lvl;
        r.chan_buf = chan_bits[ch];
      end
      default: begin
      end
    endcase
    sum = 0;
    for (i = 0; i < NUM_CHANNELS; i++) sum += longint'(chan_bits[i]);
    if (sum > longint'(TOTAL_MAX)) sum = longint'(TOTAL_MAX);
    r.total = sum[TOTAL_OUT_W-1:0];
    r.any_flag = (sum != 0);
    return r;
  endfunction

  // result beats: compare against the oldest prediction
  always @(posedge clk) begin : check_result
    report_t got;
    report_t want;
    if (!rst && done) begin
      got = {channel_buffer, remaining_grant, total_buffered, any_data};
      if (predicted_reports.size() == 0) begin
        if (mismatch_count < 10)
          $display("%0t: result beat with nothing pending: buf %0d rem %0d tot %0d any %0b",
                   $time, got.chan_buf, got.left_over, got.total, got.any_flag);
        mismatch_count++;
      end else begin
        want = predicted_reports[0];
        predicted_reports.delete(0);
        if (got !== want) begin
          if (mismatch_count < 10)
            $display("%0t: mismatch buf %0d/%0d rem %0d/%0d tot %0d/%0d any %0b/%0b (exp/got)",
                     $time, want.chan_buf, got.chan_buf, want.left_over, got.left_over,
                     want.total, got.total, want.any_flag, got.any_flag);
          mismatch_count++;
        end
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the beat, start left high
  task automatic send_cmd(op_t op, logic [CHAN_W-1:0] ch, logic [AMOUNT_W-1:0] amt,
                          logic [SLOT_W-1:0] slot);
    start        = 1'b1;
    opcode       = op;
    channel      = ch;
    amount_bits  = amt;
    current_slot = slot;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted_reports.push_back(predict_report(op, ch, amt, slot));
    @(negedge clk);
  endtask

  task automatic idle_cycles(int n);
    start = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain_results();
    start = 1'b0;
    while (predicted_reports.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_FIRST_CHANNEL: cfg_first = data[CHAN_W-1:0];
      REG_LAST_CHANNEL:  cfg_last  = data[CHAN_W-1:0];
      REG_BITS_PER_SLOT: cfg_rate  = data[RATE_W-1:0];
      default:           cfg_depth = data[DEPTH_W-1:0];
    endcase
  endtask

  // unused upper data bits get random values
  task automatic set_walk(logic [CHAN_W-1:0] first, logic [CHAN_W-1:0] last);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom);
    d[CHAN_W-1:0] = first;
    write_reg(REG_FIRST_CHANNEL, d);
    d = CFG_DATA_W'($urandom);
    d[CHAN_W-1:0] = last;
    write_reg(REG_LAST_CHANNEL, d);
  endtask

  task automatic set_bucket(logic [RATE_W-1:0] rate, logic [DEPTH_W-1:0] depth);
    logic [CFG_DATA_W-1:0] d;
    write_reg(REG_BITS_PER_SLOT, rate);
    d = CFG_DATA_W'($urandom);
    d[DEPTH_W-1:0] = depth;
    write_reg(REG_BUCKET_DEPTH, d);
  endtask

  task automatic test_arrivals();
    send_cmd(OP_ARRIVAL, 4'd0, 32'd0, 32'd0);
    send_cmd(OP_ARRIVAL, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(OP_ARRIVAL, 4'd0, 32'd5, 32'd1);            // buffer saturates
    send_cmd(OP_ARRIVAL, 4'd15, 32'd1000, 32'd2);
    send_cmd(OP_ARRIVAL, 4'd7, 32'h8000_0000, 32'd3);
    send_cmd(OP_NOP, 4'd9, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(OP_NOP, 4'd6, 32'h5555_AAAA, 32'hAAAA_5555);
  endtask

  task automatic test_grant_walk();
    send_cmd(OP_GRANT, 4'd3, 32'd777, 32'd4);            // all buckets empty
    send_cmd(OP_REFRESH, 4'd15, 32'd0, 32'd10);
    send_cmd(OP_REFRESH, 4'd15, 32'd0, 32'd10);          // no stamp, adds again
    send_cmd(OP_GRANT, 4'd0, 32'd400, 32'd11);           // short fit
    send_cmd(OP_GRANT, 4'd0, 32'd600, 32'd12);           // exact fit
    send_cmd(OP_REFRESH, 4'd0, 32'd0, 32'd5);
    send_cmd(OP_REFRESH, 4'd7, 32'd0, 32'hFFFF_FFF0);    // capped
    send_cmd(OP_GRANT, 4'd0, 32'd0, 32'd20);             // zero grant stamps ch0
    send_cmd(OP_REFRESH, 4'd0, 32'd0, 32'd3);            // slot wraps
    send_cmd(OP_GRANT, 4'd0, 32'hFFFF_FFFF, 32'd30);     // ch0 bucket goes negative
    send_cmd(OP_GRANT, 4'd0, 32'hFFFF_FFFF, 32'd31);     // ch0 skipped, ch7 short
    send_cmd(OP_REFRESH, 4'd0, 32'd0, 32'd32);
    send_cmd(OP_ARRIVAL, 4'd3, 32'd12345, 32'd33);
    send_cmd(OP_REFRESH, 4'd3, 32'd0, 32'd40);
    send_cmd(OP_GRANT, 4'd0, 32'd100000, 32'd41);
  endtask

  task automatic test_config();
    drain_results();
    set_walk(4'd9, 4'd4);                                // empty walk
    send_cmd(OP_ARRIVAL, 4'd9, 32'd50, 32'd50);
    send_cmd(OP_REFRESH, 4'd9, 32'd0, 32'd60);
    send_cmd(OP_GRANT, 4'd0, 32'd5000, 32'd61);
    drain_results();
    set_walk(4'd9, 4'd9);
    send_cmd(OP_GRANT, 4'd0, 32'd20, 32'd62);
    drain_results();
    set_walk(4'd15, 4'd15);
    set_bucket(24'd0, 16'd1);
    send_cmd(OP_ARRIVAL, 4'd15, 32'd300, 32'd63);
    send_cmd(OP_REFRESH, 4'd15, 32'd0, 32'd900);
    send_cmd(OP_GRANT, 4'd0, 32'd10, 32'd901);
    drain_results();
    set_walk(4'd0, 4'd15);
    set_bucket(24'hFF_FFFF, 16'hFFFF);
    send_cmd(OP_REFRESH, 4'd15, 32'd0, 32'h8000_0000);
    send_cmd(OP_REFRESH, 4'd2, 32'd0, 32'd1);
    send_cmd(OP_GRANT, 4'd0, 32'hFFFF_FFFF, 32'h8000_0001);
    drain_results();
    set_bucket(24'd1, 16'd1);
    send_cmd(OP_ARRIVAL, 4'd5, 32'd9, 32'd0);
    send_cmd(OP_REFRESH, 4'd5, 32'd0, 32'd1000);
    send_cmd(OP_GRANT, 4'd0, 32'd4, 32'd1001);
    send_cmd(OP_GRANT, 4'd0, 32'd4, 32'd1002);
  endtask

  task automatic run_traffic(int n, bit gaps);
    int                  burst;
    int                  r;
    op_t                 op;
    logic [AMOUNT_W-1:0] amt;
    burst = $urandom_range(1, 20);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 40) op = OP_ARRIVAL;
      else if (r < 65) op = OP_REFRESH;
      else if (r < 94) op = OP_GRANT;
      else op = OP_NOP;
      if ($urandom_range(0, 9) == 0) amt = $urandom;
      else if (op == OP_GRANT) amt = $urandom_range(0, 60000);
      else amt = $urandom_range(0, 20000);
      if ($urandom_range(0, 29) == 0) slot_clock = $urandom;
      else slot_clock = slot_clock + $urandom_range(0, 3);
      send_cmd(op, CHAN_W'($urandom_range(0, NUM_CHANNELS - 1)), amt, slot_clock);
      if (k == n / 2 && $urandom_range(0, 1) == 0) drain_results();
      burst = burst - 1;
      if (gaps && burst == 0) begin
        idle_cycles($urandom_range(1, 12));
        burst = $urandom_range(1, 20);
      end
    end
  endtask

  task automatic test_random_traffic();
    logic [CHAN_W-1:0] first;
    logic [CHAN_W-1:0] last;
    logic [RATE_W-1:0] rate;
    logic [DEPTH_W-1:0] depth;
    drain_results();
    set_walk(FIRST_CHANNEL_RST, LAST_CHANNEL_RST);
    set_bucket(BITS_PER_SLOT_RST, BUCKET_DEPTH_RST);
    run_traffic(100, 1'b1);
    for (int p = 0; p < 5; p++) begin
      drain_results();
      first = CHAN_W'($urandom_range(0, 15));
      last  = CHAN_W'($urandom_range(0, 15));
      if (first > last && $urandom_range(0, 4) != 0) begin
        first = last;
        last  = CHAN_W'($urandom_range(first, 15));
      end
      case ($urandom_range(0, 3))
        0:       rate = RATE_W'($urandom_range(0, 4000));
        1:       rate = 24'hFF_FFFF;
        default: rate = RATE_W'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0:       depth = 16'd1;
        1:       depth = 16'hFFFF;
        default: depth = DEPTH_W'($urandom_range(1, 16'hFFFF));
      endcase
      set_walk(first, last);
      set_bucket(rate, depth);
      run_traffic(100, p != 2);
    end
  endtask

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    opcode       = OP_NOP;
    channel      = '0;
    amount_bits  = '0;
    current_slot = '0;
    cfg_we       = 1'b0;
    cfg_idx      = REG_FIRST_CHANNEL;
    cfg_wdata    = '0;
    mismatch_count = 0;
    slot_clock   = '0;
    clear_shadow();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_arrivals();
    test_grant_walk();
    test_config();
    test_random_traffic();

    drain_results();
    repeat (25) @(negedge clk);
    if (mismatch_count == 0 && predicted_reports.size() == 0) begin
      $display("token_bucket_channel_prioritizer test passed");
    end else begin
      $display("token_bucket_channel_prioritizer test failed");
    end
    $finish;
  end

endmodule

>>> token_bucket_channel_prioritizer.f
+incdir+design
design/tbcp_pkg.sv
design/tbcp_alu.sv
design/tbcp_chan_store.sv
design/token_bucket_channel_prioritizer.sv
dv/tb_top.sv
